FILE: rtl/core/hrlp_pkg.sv
// ----------------------------------------------------------------------------
// hrlp_pkg
// Shared types, codes and name tables for the request line parser.
// ----------------------------------------------------------------------------
package hrlp_pkg;

  localparam int LINE_LIMIT    = 1024;
  localparam int VERSION_CHARS = 8;
  localparam int CNT_W         = 11;
  localparam int TEN_W         = 10;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [TEN_W-1:0] TEN_MAX = '1;

  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  // result status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_MALFORMED   = 2'd1;
  localparam logic [1:0] ST_UNSUPPORTED = 2'd2;

  localparam logic [1:0] VER_1_1 = 2'd1;

  // configuration register indexes
  localparam logic CFG_MAX_PATH = 1'b0;
  localparam logic CFG_MAX_LINE = 1'b1;

  localparam int NUM_METHODS  = 9;
  localparam int NUM_VERSIONS = 3;

  // names packed first character in the highest byte used
  localparam logic [55:0] METHOD_NAME [NUM_METHODS] = '{
    56'h00000000474554,   // GET
    56'h00000048454144,   // HEAD
    56'h000000504F5354,   // POST
    56'h00000000505554,   // PUT
    56'h0044454C455445,   // DELETE
    56'h4F5054494F4E53,   // OPTIONS
    56'h434F4E4E454354,   // CONNECT
    56'h00005452414345,   // TRACE
    56'h00005041544348    // PATCH
  };
  localparam int METHOD_LEN [NUM_METHODS] = '{3, 4, 4, 3, 6, 7, 7, 5, 5};

  localparam logic [63:0] VERSION_NAME [NUM_VERSIONS] = '{
    64'h485454502F312E30,   // HTTP/1.0
    64'h485454502F312E31,   // HTTP/1.1
    64'h485454502F322E30    // HTTP/2.0
  };

  typedef enum logic [1:0] {
    PH_METHOD  = 2'd0,
    PH_PATH    = 2'd1,
    PH_VERSION = 2'd2,
    PH_DONE    = 2'd3
  } phase_t;

  typedef struct packed {
    phase_t             phase;
    logic [55:0]        method_chars;
    logic [CNT_W-1:0]   token_count;
    logic [TEN_W-1:0]   path_start;
    logic [TEN_W-1:0]   path_count;
    logic [63:0]        version_chars;
    logic [CNT_W-1:0]   line_count;
    logic               cr_pending;
    logic               fault_seen;
  } parse_state_t;

  typedef struct packed {
    logic [TEN_W-1:0] path_length;
    logic [TEN_W-1:0] path_offset;
    logic [1:0]       version_code;
    logic [3:0]       method_code;
    logic [1:0]       status;
  } result_t;

  function automatic parse_state_t clear_state(phase_t ph);
    parse_state_t s;
    s = '0;
    s.phase = ph;
    return s;
  endfunction

endpackage

FILE: rtl/core/hrlp_byte_step.sv
// ----------------------------------------------------------------------------
// hrlp_byte_step
// Next parse state and optional result for one request byte.
// ----------------------------------------------------------------------------
module hrlp_byte_step (
  input  hrlp_pkg::parse_state_t  state,
  input  logic [7:0]              data_byte,
  input  logic                    first_of_request,
  input  logic                    last_of_buffer,
  input  logic [10:0]             max_path_length,
  input  logic [10:0]             max_line_length,
  output hrlp_pkg::parse_state_t  state_next,
  output logic                    res_valid,
  output hrlp_pkg::result_t       res
);
  import hrlp_pkg::*;

  typedef struct packed {
    logic       hit;
    logic [3:0] code;
  } method_hit_t;

  logic [CNT_W-1:0] line_limit;

  assign line_limit = (max_line_length < CNT_W'(LINE_LIMIT)) ? max_line_length
                                                              : CNT_W'(LINE_LIMIT);

  function automatic method_hit_t method_match(logic [55:0] chars, logic [CNT_W-1:0] len,
                                               logic use_len);
    method_hit_t r;
    r = '0;
    for (int i = 0; i < NUM_METHODS; i++) begin
      if (!r.hit && chars == METHOD_NAME[i] &&
          (!use_len || len == CNT_W'(METHOD_LEN[i]))) begin
        r.hit  = 1'b1;
        r.code = 4'(i);
      end
    end
    return r;
  endfunction

  function automatic parse_state_t take_byte(parse_state_t s, logic [7:0] c,
                                             logic [CNT_W-1:0] max_path,
                                             logic [CNT_W-1:0] limit);
    parse_state_t n;
    method_hit_t  mh;
    n  = s;
    mh = method_match(s.method_chars, s.token_count, 1'b1);
    if (n.line_count != CNT_MAX) n.line_count = n.line_count + CNT_W'(1);
    if (n.line_count > limit) n.fault_seen = 1'b1;
    case (s.phase)
      PH_METHOD: begin
        if (c == CH_SP) begin
          if (s.token_count >= max_path || !mh.hit) n.fault_seen = 1'b1;
          n.phase       = PH_PATH;
          n.path_start  = (n.line_count < {1'b0, TEN_MAX}) ? n.line_count[TEN_W-1:0]
                                                           : TEN_MAX;
          n.path_count  = '0;
          n.token_count = '0;
        end else begin
          if (s.token_count < CNT_W'(7)) n.method_chars = {s.method_chars[47:0], c};
          if (s.token_count != CNT_MAX) n.token_count = s.token_count + CNT_W'(1);
        end
      end
      PH_PATH: begin
        if (c == CH_SP) begin
          if ({1'b0, s.path_count} >= max_path) n.fault_seen = 1'b1;
          n.phase         = PH_VERSION;
          n.token_count   = '0;
          n.version_chars = '0;
        end else if (s.path_count != TEN_MAX) begin
          n.path_count = s.path_count + TEN_W'(1);
        end else begin
          n.fault_seen = 1'b1;
        end
      end
      PH_VERSION: begin
        n.version_chars = {s.version_chars[55:0], c};
        if (s.token_count != CNT_MAX) n.token_count = s.token_count + CNT_W'(1);
      end
      default: ;
    endcase
    return n;
  endfunction

  parse_state_t s0;
  parse_state_t s1;
  logic         ended;
  logic         ver_hit;
  logic [1:0]   ver_code;
  method_hit_t  fin_meth;
  logic         bad;

  always_comb begin
    s0    = first_of_request ? clear_state(PH_METHOD) : state;
    s1    = s0;
    ended = 1'b0;
    if (s0.phase != PH_DONE) begin
      if (s0.cr_pending) begin
        s1.cr_pending = 1'b0;
        if (data_byte == CH_LF) begin
          ended = 1'b1;
        end else begin
          s1 = take_byte(s1, CH_CR, max_path_length, line_limit);
          if (data_byte == CH_CR) s1.cr_pending = 1'b1;
          else s1 = take_byte(s1, data_byte, max_path_length, line_limit);
        end
      end else if (data_byte == CH_CR) begin
        s1.cr_pending = 1'b1;
      end else begin
        s1 = take_byte(s1, data_byte, max_path_length, line_limit);
      end
    end
  end

  // end of line checks on the state after this byte
  always_comb begin
    ver_hit  = 1'b0;
    ver_code = '0;
    for (int i = 0; i < NUM_VERSIONS; i++) begin
      if (!ver_hit && s1.version_chars == VERSION_NAME[i]) begin
        ver_hit  = 1'b1;
        ver_code = 2'(i);
      end
    end
    fin_meth = method_match(s1.method_chars, s1.token_count, 1'b0);
    bad = !ended || s1.fault_seen || s1.phase != PH_VERSION ||
          s1.token_count != CNT_W'(VERSION_CHARS) || !ver_hit || !fin_meth.hit;
  end

  always_comb begin
    res_valid  = (s0.phase != PH_DONE) && (ended || last_of_buffer);
    state_next = s1;
    if (res_valid) begin
      state_next.phase      = PH_DONE;
      state_next.cr_pending = 1'b0;
    end
    if (bad) begin
      res        = '0;
      res.status = ST_MALFORMED;
    end else begin
      res.status       = (ver_code == VER_1_1) ? ST_OK : ST_UNSUPPORTED;
      res.method_code  = fin_meth.code;
      res.version_code = ver_code;
      res.path_offset  = s1.path_start;
      res.path_length  = s1.path_count;
    end
  end

endmodule

FILE: rtl/core/http_request_line_parser_unit.sv
// ----------------------------------------------------------------------------
// http_request_line_parser_unit
// The byte that ends the line or the buffer goes to the input register, and
// its result to the result register on m_axis. Throughput: one byte per
// cycle while m_axis does not stall, set by the combinational parse state
// update between the input and result registers. Reset: synchronous; the
// parser waits for a first-of-request byte; limits: 255 path, 1024 line.
// ----------------------------------------------------------------------------
module http_request_line_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] first_of_request
  input  logic        s_axis_tlast,   // last_of_buffer
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] status, [5:2] method_code, [7:6] version_code,
  // [17:8] path_offset, [27:18] path_length, [31:28] zero
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data
);
  import hrlp_pkg::*;

  logic [10:0]  max_path_length;
  logic [10:0]  max_line_length;
  parse_state_t state;
  parse_state_t state_next;
  logic         in_valid;
  logic [7:0]   in_byte;
  logic         in_first;
  logic         in_last;
  logic         step_valid;
  result_t      step_res;
  result_t      res_q;
  logic         proc;

  assign proc          = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || proc;
  assign cfg_ready     = 1'b1;
  assign m_axis_tdata  = {4'b0, res_q};

  hrlp_byte_step u_step (
    .state            (state),
    .data_byte        (in_byte),
    .first_of_request (in_first),
    .last_of_buffer   (in_last),
    .max_path_length  (max_path_length),
    .max_line_length  (max_line_length),
    .state_next       (state_next),
    .res_valid        (step_valid),
    .res              (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid        <= 1'b0;
      m_axis_tvalid   <= 1'b0;
      state           <= clear_state(PH_DONE);
      max_path_length <= 11'd255;
      max_line_length <= 11'd1024;
    end else begin
      if (s_axis_tvalid && s_axis_tready) in_valid <= 1'b1;
      else if (proc) in_valid <= 1'b0;
      if (proc) begin
        state         <= state_next;
        m_axis_tvalid <= step_valid;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (cfg_valid) begin
        case (cfg_index)
          CFG_MAX_PATH: max_path_length <= cfg_data;
          CFG_MAX_LINE: max_line_length <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte  <= s_axis_tdata;
      in_first <= s_axis_tuser;
      in_last  <= s_axis_tlast;
    end
    if (proc && step_valid) res_q <= step_res;
  end

`ifndef ASSERT_OFF
  a_done_after_result: assert property (@(posedge clk) disable iff (rst)
    proc && step_valid |=> state.phase == PH_DONE)
    else $error("parser not done after a result");

  a_ok_is_1_1: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && res_q.status == ST_OK |-> res_q.version_code == VER_1_1)
    else $error("ok status with version other than 1.1");

  a_unsup_not_1_1: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && res_q.status == ST_UNSUPPORTED |-> res_q.version_code != VER_1_1)
    else $error("unsupported status with version 1.1");

  a_malformed_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && res_q.status == ST_MALFORMED |->
      res_q.method_code == 4'd0 && res_q.version_code == 2'd0 &&
      res_q.path_offset == '0 && res_q.path_length == '0)
    else $error("malformed result carries non-zero fields");
`endif

endmodule

FILE: verif/tb_http_request_line_parser_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_http_request_line_parser_unit
// Drives request byte streams into the parser and checks every line status
// against a cycle-free model of the parse. Directed lines cover each method,
// each version, malformed forms and the path and line limits; random traffic
// then mixes well-formed lines with broken ones under several idle patterns
// and limit settings.
// ----------------------------------------------------------------------------
module tb_http_request_line_parser_unit;
  import hrlp_pkg::*;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_QUOTA  = 50;

  typedef struct {
    logic [7:0] data;
    bit         sof;
    bit         eob;
  } stream_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;    // [7:0] data_byte
  logic        s_axis_tuser = 1'b0;  // [0] first_of_request
  logic        s_axis_tlast = 1'b0;  // last_of_buffer
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [1:0] status, [5:2] method_code, [7:6] version_code,
  // [17:8] path_offset, [27:18] path_length, [31:28] zero
  logic [31:0] m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [10:0] cfg_data = '0;

  http_request_line_parser_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #2 clk = ~clk;

  // parser model state and limits
  phase_t      pr_phase = PH_DONE;
  logic [55:0] pr_method;
  logic [10:0] pr_tokens;
  logic [9:0]  pr_path_start;
  logic [9:0]  pr_path_cnt;
  logic [63:0] pr_version;
  logic [10:0] pr_line;
  bit          pr_cr;
  bit          pr_fault;
  logic [10:0] lim_path = 11'd255;
  logic [10:0] lim_line = 11'd1024;

  result_t      line_results_q [$];
  stream_byte_t req_q [$];

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int error_count    = 0;
  int cycle_count    = 0;
  int counted_bytes  = 0;
  int total_bytes    = 0;
  int ignored_bytes  = 0;
  int results_checked = 0;
  int ok_count       = 0;
  int malformed_count = 0;
  int unsup_count    = 0;

  function automatic string method_text(int i);
    case (i)
      0: return "GET";
      1: return "HEAD";
      2: return "POST";
      3: return "PUT";
      4: return "DELETE";
      5: return "OPTIONS";
      6: return "CONNECT";
      7: return "TRACE";
      default: return "PATCH";
    endcase
  endfunction

  function automatic string version_text(int i);
    case (i)
      0: return "HTTP/1.0";
      1: return "HTTP/1.1";
      default: return "HTTP/2.0";
    endcase
  endfunction

  // first character ends up in the highest byte used
  function automatic logic [63:0] pack_name(string s);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < s.len(); i++) v = {v[55:0], s[i]};
    return v;
  endfunction

  function automatic int method_index(logic [55:0] chars, logic [10:0] len);
    for (int i = 0; i < 9; i++) begin
      if (method_text(i).len() == len && pack_name(method_text(i)) == {8'h00, chars}) return i;
    end
    return -1;
  endfunction

  task automatic clear_model;
    pr_method     = '0;
    pr_tokens     = '0;
    pr_path_start = '0;
    pr_path_cnt   = '0;
    pr_version    = '0;
    pr_line       = '0;
    pr_cr         = 1'b0;
    pr_fault      = 1'b0;
  endtask

  task automatic absorb_line_byte(logic [7:0] c);
    logic [10:0] limit;
    limit = (lim_line < LINE_LIMIT) ? lim_line : 11'(LINE_LIMIT);
    if (pr_line != CNT_MAX) pr_line++;
    if (pr_line > limit) pr_fault = 1'b1;
    case (pr_phase)
      PH_METHOD: begin
        if (c == CH_SP) begin
          if (pr_tokens >= lim_path || method_index(pr_method, pr_tokens) < 0) pr_fault = 1'b1;
          pr_phase      = PH_PATH;
          pr_path_start = (pr_line < TEN_MAX) ? pr_line[9:0] : TEN_MAX;
          pr_path_cnt   = '0;
          pr_tokens     = '0;
        end else begin
          if (pr_tokens < 7) pr_method = {pr_method[47:0], c};
          if (pr_tokens != CNT_MAX) pr_tokens++;
        end
      end
      PH_PATH: begin
        if (c == CH_SP) begin
          if (pr_path_cnt >= lim_path) pr_fault = 1'b1;
          pr_phase   = PH_VERSION;
          pr_tokens  = '0;
          pr_version = '0;
        end else if (pr_path_cnt < TEN_MAX) begin
          pr_path_cnt++;
        end else begin
          pr_fault = 1'b1;
        end
      end
      PH_VERSION: begin
        pr_version = {pr_version[55:0], c};
        if (pr_tokens != CNT_MAX) pr_tokens++;
      end
      default: ;
    endcase
  endtask

  task automatic close_line(bit cut_short);
    result_t r;
    int      ver;
    int      meth;
    bit      bad;
    bad  = cut_short || pr_fault || pr_phase != PH_VERSION || pr_tokens != VERSION_CHARS;
    ver  = -1;
    meth = -1;
    for (int i = 0; i < 3 && !bad; i++) begin
      if (pack_name(version_text(i)) == pr_version) begin
        ver = i;
        break;
      end
    end
    if (ver < 0) bad = 1'b1;
    // at this point only the packed characters are compared
    for (int i = 0; i < 9 && !bad; i++) begin
      if (pack_name(method_text(i)) == {8'h00, pr_method}) begin
        meth = i;
        break;
      end
    end
    if (meth < 0) bad = 1'b1;
    r = '0;
    if (bad) begin
      r.status = ST_MALFORMED;
    end else begin
      r.status       = (ver == 1) ? ST_OK : ST_UNSUPPORTED;
      r.method_code  = meth[3:0];
      r.version_code = ver[1:0];
      r.path_offset  = pr_path_start;
      r.path_length  = pr_path_cnt;
    end
    line_results_q.push_back(r);
    pr_phase = PH_DONE;
    pr_cr    = 1'b0;
  endtask

  task automatic parse_byte(logic [7:0] d, bit is_first, bit is_last);
    bit ended;
    ended = 1'b0;
    if (is_first) begin
      clear_model();
      pr_phase = PH_METHOD;
    end
    if (pr_phase == PH_DONE) begin
      ignored_bytes++;
    end else begin
      if (pr_cr) begin
        pr_cr = 1'b0;
        if (d == CH_LF) begin
          ended = 1'b1;
        end else begin
          // a cr not followed by lf is an ordinary line byte
          absorb_line_byte(CH_CR);
          if (d == CH_CR) pr_cr = 1'b1;
          else absorb_line_byte(d);
        end
      end else if (d == CH_CR) begin
        pr_cr = 1'b1;
      end else begin
        absorb_line_byte(d);
      end
      if (ended) close_line(1'b0);
      else if (is_last) close_line(1'b1);
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch: %s at result %0d, got %0d, expected %0d",
             what, results_checked, got, want);
    error_count++;
  endtask

  task automatic check_result(logic [31:0] word);
    result_t got;
    result_t want;
    got = word[27:0];
    if (word[31:28] != 4'd0) report_mismatch("padding bits", word[31:28], 0);
    if (line_results_q.size() == 0) begin
      report_mismatch("result with no line pending, tdata", word, 0);
    end else begin
      want = line_results_q.pop_front();
      if (got.status != want.status) report_mismatch("status", got.status, want.status);
      if (got.method_code != want.method_code)
        report_mismatch("method_code", got.method_code, want.method_code);
      if (got.version_code != want.version_code)
        report_mismatch("version_code", got.version_code, want.version_code);
      if (got.path_offset != want.path_offset)
        report_mismatch("path_offset", got.path_offset, want.path_offset);
      if (got.path_length != want.path_length)
        report_mismatch("path_length", got.path_length, want.path_length);
      results_checked++;
      if (want.status == ST_OK) ok_count++;
      else if (want.status == ST_MALFORMED) malformed_count++;
      else unsup_count++;
    end
  endtask

  // model update on each input transaction, then result check
  always @(posedge clk) begin
    if (rst) begin
      clear_model();
      pr_phase = PH_DONE;
      lim_path = 11'd255;
      lim_line = 11'd1024;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        total_bytes++;
        parse_byte(s_axis_tdata, s_axis_tuser, s_axis_tlast);
      end
      if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
    end
  end

  always @(negedge clk) begin
    m_axis_tready <= (sink_stall_pct == 0) || ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d lines outstanding",
               cycle_count, line_results_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // called at a falling edge; returns at the falling edge after the transaction
  task automatic send_item(stream_byte_t it);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= it.data;
    s_axis_tuser  <= it.sof;
    s_axis_tlast  <= it.eob;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic add_byte(logic [7:0] b);
    stream_byte_t it;
    it.data = b;
    it.sof  = 1'b0;
    it.eob  = 1'b0;
    req_q.push_back(it);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  function automatic logic [7:0] path_char();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    while (c == CH_SP || c == CH_CR) c = 8'($urandom_range(255));
    return c;
  endfunction

  task automatic add_path(int n);
    for (int i = 0; i < n; i++) add_byte(path_char());
  endtask

  task automatic add_line(string meth, int plen, string ver);
    add_text(meth);
    add_byte(CH_SP);
    add_path(plen);
    add_byte(CH_SP);
    add_text(ver);
  endtask

  task automatic add_crlf;
    add_byte(CH_CR);
    add_byte(CH_LF);
  endtask

  task automatic send_req(bit mark_first, bit mark_last, bit counted);
    if (req_q.size() != 0) begin
      if (mark_first) req_q[0].sof = 1'b1;
      if (mark_last) req_q[req_q.size()-1].eob = 1'b1;
      if (counted) counted_bytes += req_q.size();
      foreach (req_q[i]) send_item(req_q[i]);
      req_q.delete();
    end
  endtask

  task automatic send_request_line(string meth, int plen, string ver);
    add_line(meth, plen, ver);
    add_crlf();
    send_req(1'b1, 1'b0, 1'b0);
  endtask

  // closes any open line, then waits out the pipeline
  task automatic wait_idle;
    stream_byte_t closer;
    if (pr_phase != PH_DONE) begin
      closer.data = "X";
      closer.sof  = 1'b1;
      closer.eob  = 1'b1;
      send_item(closer);
    end
    s_axis_tvalid <= 1'b0;
    while (line_results_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, int value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[10:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_MAX_PATH) lim_path = value[10:0];
    else lim_line = value[10:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic string bad_version();
    string s;
    case ($urandom_range(5))
      0: return "HTTP/1.2";
      1: return "HTTP/3.0";
      2: return "http/1.1";
      3: return "HTTP/1.1x";
      4: return "HTTP/1";
      default: begin
        s = "12345678";
        for (int i = 0; i < 8; i++) s[i] = 8'($urandom_range(1, 255));
        return s;
      end
    endcase
  endfunction

  function automatic int pick_path_len();
    if ($urandom_range(9) < 7) return $urandom_range(0, 12);
    if (lim_path > 48) return $urandom_range(13, 40);
    if (lim_path == 0) return 0;
    return lim_path - 1 + $urandom_range(1);
  endfunction

  task automatic random_request;
    int    kind;
    string meth;
    string ver;
    int    n;
    kind = $urandom_range(99);
    meth = method_text($urandom_range(8));
    ver  = ($urandom_range(9) < 8) ? version_text($urandom_range(2)) : bad_version();
    if (kind < 65) begin
      add_line(meth, pick_path_len(), ver);
      add_crlf();
      send_req(1'b1, $urandom_range(3) == 0, 1'b1);
    end else begin
      case ($urandom_range(8))
        0: begin
          add_path($urandom_range(0, 9));
          add_byte(CH_SP);
          add_path($urandom_range(0, 4));
          add_byte(CH_SP);
          add_text(version_text(1));
          add_crlf();
          send_req(1'b1, 1'b0, 1'b1);
        end
        1: begin
          if ($urandom_range(1)) begin
            add_line(meth, pick_path_len(), ver);
            add_byte(CH_SP);
          end else begin
            add_line(meth, pick_path_len(), {" ", ver});
          end
          add_crlf();
          send_req(1'b1, 1'b0, 1'b1);
        end
        2: begin
          // lone cr inside the path
          add_text(meth);
          add_byte(CH_SP);
          add_path($urandom_range(0, 4));
          add_byte(CH_CR);
          add_byte(path_char());
          add_path($urandom_range(0, 4));
          add_byte(CH_SP);
          add_text(ver);
          add_crlf();
          send_req(1'b1, 1'b0, 1'b1);
        end
        3: begin
          add_line(meth, pick_path_len(), ver);
          add_crlf();
          n = $urandom_range(1, req_q.size());
          while (req_q.size() > n) void'(req_q.pop_back());
          send_req(1'b1, 1'b1, 1'b1);
        end
        4: begin
          n = $urandom_range(1, 20);
          for (int i = 0; i < n; i++) add_byte(8'($urandom_range(255)));
          if ($urandom_range(1)) add_crlf();
          send_req(1'b1, $urandom_range(1), 1'b1);
        end
        5: begin
          add_byte(8'($urandom_range(255)));
          send_req(1'b1, 1'b1, 1'b1);
        end
        6: begin
          // cut off by the next request start
          add_line(meth, pick_path_len(), ver);
          n = $urandom_range(1, req_q.size());
          while (req_q.size() > n) void'(req_q.pop_back());
          send_req(1'b1, 1'b0, 1'b1);
        end
        7: begin
          add_line(meth, pick_path_len(), ver);
          add_byte(CH_CR);
          add_crlf();
          send_req(1'b1, 1'b0, 1'b1);
        end
        default: begin
          add_line(meth, pick_path_len(), ver);
          add_byte(CH_CR);
          send_req(1'b1, 1'b1, 1'b1);
        end
      endcase
    end
    // trailing bytes that the parser should drop
    if (pr_phase == PH_DONE && $urandom_range(4) == 0) begin
      n = $urandom_range(1, 5);
      for (int i = 0; i < n; i++) add_byte(8'($urandom_range(255)));
      send_req(1'b0, $urandom_range(1), 1'b0);
    end
  endtask

  task automatic test_methods_versions;
    for (int i = 0; i < 9; i++) send_request_line(method_text(i), 1 + i % 4, "HTTP/1.1");
    send_request_line("GET", 2, "HTTP/1.0");
    send_request_line("PUT", 1, "HTTP/2.0");
    // extreme byte values inside the path
    add_text("POST ");
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(CH_LF);
    add_text(" HTTP/1.1");
    add_crlf();
    send_req(1'b1, 1'b0, 1'b0);
  endtask

  task automatic test_malformed_lines;
    send_request_line("GOT", 2, "HTTP/1.1");
    send_request_line("get", 2, "HTTP/1.1");
    send_request_line("OPTIONSX", 2, "HTTP/1.1");
    send_request_line("", 2, "HTTP/1.1");
    send_request_line("GET", 0, "HTTP/1.1");
    send_request_line("GET", 2, "HTTP/1.2");
    send_request_line("GET", 2, "HTTP/1");
    // version with spaces, before and after
    send_request_line("GET", 1, " HTTP/1.1");
    send_request_line("GET", 1, "HTTP/1.1 ");
    // lone cr in the path is an ordinary byte
    add_text("GET /a");
    add_byte(CH_CR);
    add_text("b HTTP/1.1");
    add_crlf();
    send_req(1'b1, 1'b0, 1'b0);
    // double cr puts a cr into the version
    add_line("HEAD", 1, "HTTP/1.1");
    add_byte(CH_CR);
    add_crlf();
    send_req(1'b1, 1'b0, 1'b0);
    add_text("GETGETGET");
    add_crlf();
    send_req(1'b1, 1'b0, 1'b0);
    // buffer ends: without crlf, on a cr, and on the lf itself
    add_line("GET", 1, "HTTP/1.1");
    send_req(1'b1, 1'b1, 1'b0);
    add_line("GET", 1, "HTTP/1.1");
    add_byte(CH_CR);
    send_req(1'b1, 1'b1, 1'b0);
    add_line("DELETE", 3, "HTTP/2.0");
    add_crlf();
    send_req(1'b1, 1'b1, 1'b0);
    // first and last on one byte
    add_byte("G");
    send_req(1'b1, 1'b1, 1'b0);
    // bytes after the line end are dropped
    add_text("junk ");
    add_crlf();
    send_req(1'b0, 1'b1, 1'b0);
    // new request start while a line is open
    add_text("GET /abc");
    send_req(1'b1, 1'b0, 1'b0);
    send_request_line("TRACE", 1, "HTTP/1.1");
    // line limit and zero path limit
    write_reg(CFG_MAX_LINE, 8);
    send_request_line("GET", 1, "HTTP/1.1");
    write_reg(CFG_MAX_LINE, 1024);
    write_reg(CFG_MAX_PATH, 0);
    send_request_line("GET", 1, "HTTP/1.1");
    write_reg(CFG_MAX_PATH, 255);
  endtask

  task automatic test_limits;
    write_reg(CFG_MAX_PATH, 4);
    send_request_line("GET", 3, "HTTP/1.1");
    send_request_line("GET", 4, "HTTP/1.1");
    send_request_line("HEAD", 1, "HTTP/1.1");
    write_reg(CFG_MAX_PATH, 255);
    write_reg(CFG_MAX_LINE, 16);
    send_request_line("GET", 3, "HTTP/1.1");
    send_request_line("GET", 4, "HTTP/1.1");
    // line limit saturates, path counter reaches its maximum
    write_reg(CFG_MAX_PATH, 2047);
    write_reg(CFG_MAX_LINE, 2047);
    send_request_line("PATCH", 1030, "HTTP/1.1");
    write_reg(CFG_MAX_PATH, 255);
    write_reg(CFG_MAX_LINE, 1024);
  endtask

  task automatic test_random_traffic(int idle_src, int stall_sink, int path_lim, int line_lim);
    int start;
    write_reg(CFG_MAX_PATH, path_lim);
    write_reg(CFG_MAX_LINE, line_lim);
    src_idle_pct   = idle_src;
    sink_stall_pct = stall_sink;
    start = counted_bytes;
    while (counted_bytes - start < RANDOM_QUOTA) random_request();
    wait_idle();
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_methods_versions();
    test_malformed_lines();
    test_limits();
    test_random_traffic(0, 0, 1024, 1024);
    test_random_traffic(62, 0, $urandom_range(5, 40), $urandom_range(24, 80));
    test_random_traffic(0, 62, 255, 1024);
    test_random_traffic(10, 10, $urandom_range(1, 1024), $urandom_range(8, 1024));
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    wait_idle();
    repeat (20) @(negedge clk);
    $display("run covered %0d byte transactions (%0d dropped outside a line), %0d line results",
             total_bytes, ignored_bytes, results_checked);
    $display("status mix: %0d ok, %0d malformed, %0d unsupported version",
             ok_count, malformed_count, unsup_count);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: http_request_line_parser_unit.f
rtl/core/hrlp_pkg.sv
rtl/core/hrlp_byte_step.sv
rtl/core/http_request_line_parser_unit.sv
verif/tb_http_request_line_parser_unit.sv
